// ----- rtl/lap3_pkg.sv -----
// Shared types, register codes and channel arithmetic for the 3x3 Laplacian filter.
// No dependencies; used by laplacian_3x3_rgb_filter_core.
package lap3_pkg;

	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 13;
	localparam int CFG_DW      = 13;
	localparam int CFG_AW      = 2;

	localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd1;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 13'd480;

	// last member sits in the lowest bits, so red is the low byte
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	// one line-store entry: the two rows above the incoming one
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_t;

	// border and framing flags of the pixel a request produces
	typedef struct packed {
		logic emit;
		logic up_ok;
		logic dn_ok;
		logic lf_ok;
		logic rt_ok;
		logic last;
	} tap_ctl_t;

	localparam int LINE_DW = $bits(line_t);

	function automatic logic [7:0] lap_chan(input logic [7:0] up, input logic [7:0] dn,
	                                        input logic [7:0] lf, input logic [7:0] rt,
	                                        input logic [7:0] ce);
		logic signed [11:0] s;
		s = $signed({4'b0, up}) + $signed({4'b0, dn}) + $signed({4'b0, lf})
		  + $signed({4'b0, rt}) - $signed({2'b0, ce, 2'b0});
		if (s < 0)
			return 8'd0;
		else if (s > 12'sd255)
			return 8'd255;
		else
			return s[7:0];
	endfunction

endpackage

// ----- rtl/lap3_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old contents. No dependencies.
module lap3_ram #(
	parameter int DW    = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- rtl/laplacian_3x3_rgb_filter_core.sv -----
// Top level of the 3x3 Laplacian RGB filter: position counters, line RAM, window, output.
// Depends on lap3_pkg and lap3_ram.
//
// Streams an RGB frame in raster order and returns, per channel, up+down+left+right-4*centre
// clamped to 0..255, with pixels outside the frame taken as zero. One request is taken every clock
// unless the output stalls: the line RAM (one read and one write per cycle, both rows in one word)
// and the window registers each see one pixel a cycle. A result passes stage 1 and the output
// register after the request that completes its window; in frame terms output lags input by one
// row plus one pixel, so image_width+1 flush requests (tuser set) must follow the frame. Flush
// requests during the frame are dropped, pixels after the frame count as zero. The last output of
// a frame carries tlast and the position then returns to the frame start. Width and height are
// clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT; size register writes restart the frame position.
// The line RAM is not cleared after reset; its unwritten entries only ever meet masked taps.
module laplacian_3x3_rgb_filter_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lap3_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [lap3_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // red_in, green_in, blue_in
	input  logic                          s_tuser,  // flush
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,  // red_out, green_out, blue_out
	output logic                          m_tlast   // last_pixel
);

	import lap3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int AW = $clog2(MAX_WIDTH);

	// configuration
	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [CW-1:0]          w_eff, w_m1;
	logic [RW-1:0]          h_eff, h_m1, h_p1;

	// position of the next request
	logic [CW-1:0] col_q, col_e, col_nx;
	logic [RW-1:0] row_q, row_e, row_nx;

	logic          s_acc, ignore, in_frame, pos_bad;
	logic [RW-1:0] orow;
	logic [CW-1:0] ocol;
	tap_ctl_t      ctl_calc;
	pix_t          v_calc;

	// stage 1
	logic          s1_valid;
	tap_ctl_t      ctl_s1;
	pix_t          v_s1;
	logic [AW-1:0] addr_s1;
	logic          fwd_sel_s1;
	line_t         fwd_s1;
	logic          adv;

	line_t ram_rd, line_rd, line_wr;

	// window columns that are still needed
	pix_t win2_q, win4_q, win5_q, win8_q;
	pix_t up, dn, lf, rt, ce;

	always_comb begin
		if (width_q == '0)
			w_eff = CW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(width_q);
		if (height_q == '0)
			h_eff = RW'(1);
		else if (32'(height_q) > 32'(MAX_HEIGHT))
			h_eff = RW'(MAX_HEIGHT);
		else
			h_eff = RW'(height_q);
	end

	assign w_m1 = w_eff - CW'(1);
	assign h_m1 = h_eff - RW'(1);
	assign h_p1 = h_eff + RW'(1);

	// stale position after a size change falls back to the frame start
	assign pos_bad  = (col_q >= w_eff) || (row_q > h_p1);
	assign col_e    = pos_bad ? '0 : col_q;
	assign row_e    = pos_bad ? '0 : row_q;
	assign in_frame = row_e < h_eff;
	assign ignore   = in_frame && s_tuser;
	assign v_calc   = in_frame ? pix_t'(s_tdata) : '0;

	always_comb begin
		if (col_e == '0) begin
			orow = row_e - RW'(2);
			ocol = w_m1;
		end else begin
			orow = row_e - RW'(1);
			ocol = col_e - CW'(1);
		end
		ctl_calc.emit  = (row_e >= RW'(2)) || (row_e == RW'(1) && col_e != '0);
		ctl_calc.up_ok = orow != '0;
		ctl_calc.dn_ok = orow < h_m1;
		ctl_calc.lf_ok = ocol != '0;
		ctl_calc.rt_ok = ocol < w_m1;
		ctl_calc.last  = ctl_calc.emit && (orow == h_m1) && (ocol == w_m1);
	end

	always_comb begin
		if (ctl_calc.last) begin
			col_nx = '0;
			row_nx = '0;
		end else if (col_e + CW'(1) == w_eff) begin
			col_nx = '0;
			row_nx = row_e + RW'(1);
		end else begin
			col_nx = col_e + CW'(1);
			row_nx = row_e;
		end
	end

	assign adv      = s1_valid && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid || adv;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WIDTH: begin
					width_q <= cfg_wdata[WIDTH_BITS-1:0];
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_wdata[HEIGHT_BITS-1:0];
					col_q    <= '0;
					row_q    <= '0;
				end
				default: ;
			endcase
		end else if (s_acc) begin
			if (ignore) begin
				col_q <= col_e;
				row_q <= row_e;
			end else begin
				col_q <= col_nx;
				row_q <= row_nx;
			end
		end
	end

	lap3_ram #(
		.DW    (LINE_DW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (adv),
		.waddr (addr_s1),
		.wdata (line_wr),
		.re    (s_acc),
		.raddr (col_e[AW-1:0]),
		.rdata (ram_rd)
	);

	assign line_rd        = fwd_sel_s1 ? fwd_s1 : ram_rd;
	assign line_wr.upper  = line_rd.middle;
	assign line_wr.middle = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (s_acc && !ignore)
			s1_valid <= 1'b1;
		else if (adv)
			s1_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ctl_s1     <= ctl_calc;
			v_s1       <= v_calc;
			addr_s1    <= col_e[AW-1:0];
			// RAM returns the old word when the entry is being written this edge
			fwd_sel_s1 <= adv && (addr_s1 == col_e[AW-1:0]);
			fwd_s1     <= line_wr;
		end
	end

	assign up = ctl_s1.up_ok ? win2_q : '0;
	assign dn = ctl_s1.dn_ok ? win8_q : '0;
	assign lf = ctl_s1.lf_ok ? win4_q : '0;
	assign rt = ctl_s1.rt_ok ? line_rd.middle : '0;
	assign ce = win5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win2_q <= '0;
			win4_q <= '0;
			win5_q <= '0;
			win8_q <= '0;
		end else if (adv) begin
			win2_q <= line_rd.upper;
			win4_q <= win5_q;
			win5_q <= line_rd.middle;
			win8_q <= v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (adv)
			m_tvalid <= ctl_s1.emit;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata[7:0]   <= lap_chan(up.red,   dn.red,   lf.red,   rt.red,   ce.red);
			m_tdata[15:8]  <= lap_chan(up.green, dn.green, lf.green, rt.green, ce.green);
			m_tdata[23:16] <= lap_chan(up.blue,  dn.blue,  lf.blue,  rt.blue,  ce.blue);
			m_tlast        <= ctl_s1.last;
		end
	end

	// position never leaves the frame window while the sizes are stable
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < w_eff) && (row_q <= h_p1))
		else $error("frame position out of range");

	// the request producing the last pixel restarts the frame
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !ignore && ctl_calc.last && !cfg_we) |=> (col_q == '0 && row_q == '0))
		else $error("frame position not restarted after last pixel");

	// a request that produces a pixel reaches the output register when stage 1 moves on
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl_s1.emit) |=> (m_tvalid && m_tlast == $past(ctl_s1.last)))
		else $error("stage 1 result lost");

endmodule
